// ===== design/cerp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cerp_pkg
// Shared widths, register codes, stage tag and the raised-cosine ease table.
// ----------------------------------------------------------------------------
package cerp_pkg;

   localparam int EASE_TABLE_ENTRIES = 256;
   localparam int PHASE_BITS         = 16;
   localparam int DUTY_BITS          = 16;

   localparam int CSR_DATA_BITS  = 16;
   localparam int CSR_INDEX_BITS = 2;
   localparam int INC_BITS       = 16;

   // ease values are Q.16 in 0 .. 65536
   localparam int EASE_FRAC_BITS = 16;
   localparam int EASE_W         = EASE_FRAC_BITS + 1;
   localparam int ENTRY_BITS     = $clog2(EASE_TABLE_ENTRIES);
   localparam int FRAC_BITS      = PHASE_BITS - ENTRY_BITS;
   localparam int SUM_W          = ((PHASE_BITS > INC_BITS) ? PHASE_BITS : INC_BITS) + 1;

   localparam logic [DUTY_BITS-1:0] RAMP_LOW_RESET  = DUTY_BITS'(700);
   localparam logic [DUTY_BITS-1:0] RAMP_HIGH_RESET = DUTY_BITS'(8191);
   localparam logic [INC_BITS-1:0]  PHASE_INC_RESET = INC_BITS'(437);

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_RAMP_LOW  = 2'd0,
      CSR_RAMP_HIGH = 2'd1,
      CSR_PHASE_INC = 2'd2
   } csr_index_type;

   // travels alongside the payload through each stage
   typedef struct packed {
      logic valid;
      logic falling;
      logic ramp_wrapped;
   } tag_type;

   typedef logic [EASE_W-1:0] ease_tab_type [0:EASE_TABLE_ENTRIES];

   localparam logic [63:0] Q30_ONE         = 64'd1073741824;
   localparam logic [63:0] PI_Q30          = 64'd3373259426;
   localparam logic [63:0] ENTRIES_64      = 64'(EASE_TABLE_ENTRIES);
   localparam logic [63:0] TAYLOR_DIV [1:7] = '{64'd2, 64'd12, 64'd30, 64'd56,
                                               64'd90, 64'd132, 64'd182};

   // cos(pi*j/N) in Q.30, truncated Taylor series in Horner form
   function automatic logic [63:0] cos_q30(input logic [63:0] j);
      logic [63:0] theta;
      logic [63:0] t2;
      logic [63:0] acc;
      logic [63:0] term;
      theta = (PI_Q30 * j) / ENTRIES_64;
      t2    = (theta * theta) >> 30;
      acc   = Q30_ONE;
      for (int k = 7; k >= 1; k--) begin
         term = ((t2 * acc) >> 30) / TAYLOR_DIV[k];
         acc  = (term >= Q30_ONE) ? 64'd0 : Q30_ONE - term;
      end
      return acc;
   endfunction

   function automatic ease_tab_type build_ease_tab();
      ease_tab_type tab;
      logic [63:0]  twice;
      for (int i = 0; i <= EASE_TABLE_ENTRIES; i++) begin
         if (2 * i <= EASE_TABLE_ENTRIES) begin
            twice = Q30_ONE - cos_q30(64'(i));
         end else begin
            twice = Q30_ONE + cos_q30(64'(EASE_TABLE_ENTRIES - i));
         end
         tab[i] = EASE_W'((twice + 64'd16384) >> 15);
      end
      return tab;
   endfunction

   localparam ease_tab_type EASE_TAB = build_ease_tab();

endpackage

// ===== design/cosine_eased_pingpong_ramp_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cosine_eased_pingpong_ramp_core
// Raised-cosine ping-pong duty ramp: one duty result per tick transfer.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel: one tick per transfer. req_advance = 1 moves the phase on
//   by phase_increment after the duty is taken; 0 only reports the duty.
//   rsp_ channel: one result per tick, in order: rsp_duty, rsp_falling (the
//   direction used) and rsp_ramp_wrapped (this tick reached 1.0, reset the
//   phase and flipped direction).
//   csr_ channel: csr_index 0 ramp_low, 1 ramp_high, 2 phase_increment,
//   other indexes ignored; always ready. Write only while no tick is in flight.
// Timing:
//   A req_ transfer reaches rsp_valid through registered steps: table read,
//   interpolation multiply, span multiply into the result register.
//   Throughput: one tick per cycle unless stalled; the phase/direction update
//   is a single add at the req_ transfer, so back-to-back ticks see the new phase.
// Reset: phase 0, rising, registers at 700 / 8191 / 437, pipeline empty.
// Stall: with rsp_valid high and rsp_ready low the whole pipeline holds and
//   req_ready drops; it resumes in the cycle rsp_ready returns.
// ----------------------------------------------------------------------------
module cosine_eased_pingpong_ramp_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_advance,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [cerp_pkg::DUTY_BITS-1:0]      rsp_duty,
   output logic                                rsp_falling,
   output logic                                rsp_ramp_wrapped,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [cerp_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [cerp_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   logic [cerp_pkg::DUTY_BITS-1:0]  ramp_low_in, ramp_low_ff;
   logic [cerp_pkg::DUTY_BITS-1:0]  ramp_high_in, ramp_high_ff;
   logic [cerp_pkg::INC_BITS-1:0]   phase_inc_in, phase_inc_ff;
   logic [cerp_pkg::PHASE_BITS-1:0] phase_in, phase_ff;
   logic                            direction_in, direction_ff;

   logic                            advance_en;
   logic                            req_xfer;
   logic                            csr_xfer;
   logic [cerp_pkg::SUM_W-1:0]      phase_sum;
   logic                            phase_wrap;

   cerp_pkg::tag_type               tag_s0;
   cerp_pkg::tag_type               tag_ease;
   cerp_pkg::tag_type               tag_rsp;
   logic [cerp_pkg::EASE_W-1:0]     ease;

   assign advance_en = !tag_rsp.valid || rsp_ready;
   assign req_ready  = advance_en;
   assign req_xfer   = req_valid && req_ready;
   assign csr_ready  = 1'b1;
   assign csr_xfer   = csr_valid && csr_ready;

   // configuration registers
   always_comb begin
      ramp_low_in  = ramp_low_ff;
      ramp_high_in = ramp_high_ff;
      phase_inc_in = phase_inc_ff;
      if (csr_xfer) begin
         case (csr_index)
            cerp_pkg::CSR_RAMP_LOW:  ramp_low_in  = cerp_pkg::DUTY_BITS'(csr_wdata);
            cerp_pkg::CSR_RAMP_HIGH: ramp_high_in = cerp_pkg::DUTY_BITS'(csr_wdata);
            cerp_pkg::CSR_PHASE_INC: phase_inc_in = cerp_pkg::INC_BITS'(csr_wdata);
            default: ;
         endcase
      end
   end

   // phase accumulator; reaching 1.0 drops the excess and flips direction
   always_comb begin
      phase_sum    = cerp_pkg::SUM_W'(phase_ff) + cerp_pkg::SUM_W'(phase_inc_ff);
      phase_wrap   = |phase_sum[cerp_pkg::SUM_W-1:cerp_pkg::PHASE_BITS];
      phase_in     = phase_ff;
      direction_in = direction_ff;
      if (req_xfer && req_advance) begin
         if (phase_wrap) begin
            phase_in     = '0;
            direction_in = !direction_ff;
         end else begin
            phase_in = phase_sum[cerp_pkg::PHASE_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ramp_low_ff  <= cerp_pkg::RAMP_LOW_RESET;
         ramp_high_ff <= cerp_pkg::RAMP_HIGH_RESET;
         phase_inc_ff <= cerp_pkg::PHASE_INC_RESET;
         phase_ff     <= '0;
         direction_ff <= 1'b0;
      end else begin
         ramp_low_ff  <= ramp_low_in;
         ramp_high_ff <= ramp_high_in;
         phase_inc_ff <= phase_inc_in;
         phase_ff     <= phase_in;
         direction_ff <= direction_in;
      end
   end

   always_comb begin
      tag_s0.valid        = req_valid;
      tag_s0.falling      = direction_ff;
      tag_s0.ramp_wrapped = req_advance && phase_wrap;
   end

   cerp_ease_lookup u_ease (
      .clock      (clock),
      .reset      (reset),
      .advance_en (advance_en),
      .phase      (phase_ff),
      .tag_in     (tag_s0),
      .ease       (ease),
      .tag_out    (tag_ease)
   );

   cerp_duty_blend u_blend (
      .clock      (clock),
      .reset      (reset),
      .advance_en (advance_en),
      .ease       (ease),
      .tag_in     (tag_ease),
      .ramp_low   (ramp_low_ff),
      .ramp_high  (ramp_high_ff),
      .duty       (rsp_duty),
      .tag_out    (tag_rsp)
   );

   assign rsp_valid        = tag_rsp.valid;
   assign rsp_falling      = tag_rsp.falling;
   assign rsp_ramp_wrapped = tag_rsp.ramp_wrapped;

   a_wrap_clears_phase: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && req_advance && phase_wrap) |=>
         (phase_ff == '0 && direction_ff != $past(direction_ff)))
      else $error("wrap did not clear phase and flip direction");

   a_phase_moves_on_advance_only: assert property (@(posedge clock) disable iff (reset)
      !(req_xfer && req_advance) |=> ($stable(phase_ff) && $stable(direction_ff)))
      else $error("phase changed without an advancing tick");

   a_no_wrap_keeps_direction: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && req_advance && !phase_wrap) |=>
         (direction_ff == $past(direction_ff) &&
          phase_ff == $past(phase_sum[cerp_pkg::PHASE_BITS-1:0])))
      else $error("direction or phase wrong on an advance without wrap");

endmodule

// ===== design/cerp_ease_lookup.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cerp_ease_lookup
// Two stages: table read of the neighboring entries, then linear interpolation.
// ----------------------------------------------------------------------------
module cerp_ease_lookup (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              advance_en,
   input  logic [cerp_pkg::PHASE_BITS-1:0]   phase,
   input  cerp_pkg::tag_type                 tag_in,
   output logic [cerp_pkg::EASE_W-1:0]       ease,
   output cerp_pkg::tag_type                 tag_out
);

   logic [cerp_pkg::ENTRY_BITS-1:0] idx;
   logic [cerp_pkg::ENTRY_BITS:0]   lo_addr;
   logic [cerp_pkg::ENTRY_BITS:0]   hi_addr;
   logic [cerp_pkg::EASE_W-1:0]     lo_in, lo_ff;
   logic [cerp_pkg::EASE_W-1:0]     hi_in, hi_ff;
   logic [cerp_pkg::FRAC_BITS-1:0]  frac_in, frac_ff;
   cerp_pkg::tag_type               tag1_ff, tag2_ff;

   logic [cerp_pkg::EASE_W-1:0]                     delta;
   logic [cerp_pkg::EASE_W+cerp_pkg::FRAC_BITS-1:0] prod;
   logic [cerp_pkg::EASE_W-1:0]                     step;
   logic [cerp_pkg::EASE_W-1:0]                     ease_in, ease_ff;

   // stage 1: table read
   always_comb begin
      idx     = phase[cerp_pkg::PHASE_BITS-1 -: cerp_pkg::ENTRY_BITS];
      lo_addr = {1'b0, idx};
      hi_addr = lo_addr + (cerp_pkg::ENTRY_BITS+1)'(1);
      lo_in   = cerp_pkg::EASE_TAB[lo_addr];
      hi_in   = cerp_pkg::EASE_TAB[hi_addr];
      frac_in = phase[cerp_pkg::FRAC_BITS-1:0];
   end

   // stage 2: interpolate, fraction truncated
   always_comb begin
      delta = (hi_ff >= lo_ff) ? (hi_ff - lo_ff) : (lo_ff - hi_ff);
      prod  = (cerp_pkg::EASE_W+cerp_pkg::FRAC_BITS)'(delta) *
              (cerp_pkg::EASE_W+cerp_pkg::FRAC_BITS)'(frac_ff);
      step  = cerp_pkg::EASE_W'(prod >> cerp_pkg::FRAC_BITS);
      ease_in = (hi_ff >= lo_ff) ? (lo_ff + step) : (lo_ff - step);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff <= '0;
         tag2_ff <= '0;
      end else if (advance_en) begin
         tag1_ff <= tag_in;
         tag2_ff <= tag1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance_en) begin
         lo_ff   <= lo_in;
         hi_ff   <= hi_in;
         frac_ff <= frac_in;
         ease_ff <= ease_in;
      end
   end

   assign ease    = ease_ff;
   assign tag_out = tag2_ff;

   localparam logic [cerp_pkg::EASE_W-1:0] EASE_ONE = cerp_pkg::EASE_W'(65536);

   a_ease_in_range: assert property (@(posedge clock) disable iff (reset)
      tag2_ff.valid |-> ease_ff <= EASE_ONE)
      else $error("ease value above one");

   a_table_monotonic: assert property (@(posedge clock) disable iff (reset)
      tag1_ff.valid |-> hi_ff >= lo_ff)
      else $error("ease table entries out of order");

endmodule

// ===== design/cerp_duty_blend.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cerp_duty_blend
// Scales the ease value onto the endpoint span and holds the result register.
// ----------------------------------------------------------------------------
module cerp_duty_blend (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              advance_en,
   input  logic [cerp_pkg::EASE_W-1:0]       ease,
   input  cerp_pkg::tag_type                 tag_in,
   input  logic [cerp_pkg::DUTY_BITS-1:0]    ramp_low,
   input  logic [cerp_pkg::DUTY_BITS-1:0]    ramp_high,
   output logic [cerp_pkg::DUTY_BITS-1:0]    duty,
   output cerp_pkg::tag_type                 tag_out
);

   localparam int PROD_W = cerp_pkg::EASE_W + cerp_pkg::DUTY_BITS;

   logic [cerp_pkg::DUTY_BITS-1:0] start_val, end_val, span;
   logic                           going_up;
   logic [PROD_W-1:0]              prod;
   logic [PROD_W:0]                prod_up;
   logic [cerp_pkg::DUTY_BITS-1:0] step;
   logic [cerp_pkg::DUTY_BITS-1:0] duty_in, duty_ff;
   cerp_pkg::tag_type              tag_ff;

   always_comb begin
      start_val = tag_in.falling ? ramp_high : ramp_low;
      end_val   = tag_in.falling ? ramp_low : ramp_high;
      going_up  = end_val >= start_val;
      span      = going_up ? (end_val - start_val) : (start_val - end_val);
      prod      = PROD_W'(ease) * PROD_W'(span);
      // downward step rounds up so the duty stays the floor of the exact value
      prod_up   = (PROD_W+1)'(prod) + (PROD_W+1)'(65535);
      if (going_up) begin
         step    = cerp_pkg::DUTY_BITS'(prod >> cerp_pkg::EASE_FRAC_BITS);
         duty_in = start_val + step;
      end else begin
         step    = cerp_pkg::DUTY_BITS'(prod_up >> cerp_pkg::EASE_FRAC_BITS);
         duty_in = start_val - step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= '0;
      end else if (advance_en) begin
         tag_ff <= tag_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance_en) begin
         duty_ff <= duty_in;
      end
   end

   assign duty    = duty_ff;
   assign tag_out = tag_ff;

   a_duty_between_ends: assert property (@(posedge clock) disable iff (reset)
      tag_ff.valid |->
         ((duty_ff >= ramp_low && duty_ff <= ramp_high) ||
          (duty_ff >= ramp_high && duty_ff <= ramp_low)))
      else $error("duty outside the endpoint range");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the raised-cosine ping-pong duty ramp core.
// A scoreboard keeps its own ease table, phase, direction and register copy,
// predicts every tick result, and compares rsp_ transfers in order. Directed
// ticks hit endpoint and increment extremes, then random register settings
// run long ramp sequences with random idle on both channels.
// ----------------------------------------------------------------------------
module tb_top;

   localparam logic [cerp_pkg::CSR_INDEX_BITS-1:0] CSR_SPARE = 2'd3;  // no register here
   localparam int QUIET_LIMIT    = 1000;
   localparam int DRAIN_CYCLES   = 8;
   localparam int RAND_SEGMENTS  = 12;
   localparam int SEGMENT_TICKS  = 120;
   localparam int STEADY_SEGMENT = 5;

   class duty_scoreboard;

      typedef struct {
         logic [cerp_pkg::DUTY_BITS-1:0] duty;
         logic                           falling;
         logic                           wrapped;
      } duty_result_type;

      longint unsigned                 ease_tab [cerp_pkg::EASE_TABLE_ENTRIES+1];
      logic [cerp_pkg::DUTY_BITS-1:0]  ramp_low;
      logic [cerp_pkg::DUTY_BITS-1:0]  ramp_high;
      logic [cerp_pkg::INC_BITS-1:0]   phase_step;
      logic [cerp_pkg::PHASE_BITS-1:0] phase;
      logic                            falling;
      duty_result_type                 pending_q [$];
      int                              failures;
      int                              ticks;
      int                              wraps;
      int                              falling_ticks;
      int                              reg_writes;
      int                              checked;

      // cos(pi*j/N) in Q.30 on the first quarter, truncated Taylor series
      function longint unsigned cosine_q30(longint unsigned j);
         longint unsigned one;
         longint unsigned theta;
         longint unsigned t2;
         longint unsigned acc;
         longint unsigned term;
         one   = 64'd1 << 30;
         theta = (64'd3373259426 * j) / cerp_pkg::EASE_TABLE_ENTRIES;
         t2    = (theta * theta) >> 30;
         acc   = one;
         for (int k = 7; k >= 1; k--) begin
            term = ((t2 * acc) >> 30) / ((2 * k - 1) * (2 * k));
            acc  = (term >= one) ? 64'd0 : one - term;
         end
         return acc;
      endfunction

      function new();
         longint unsigned one;
         longint unsigned twice;
         one = 64'd1 << 30;
         for (int i = 0; i <= cerp_pkg::EASE_TABLE_ENTRIES; i++) begin
            if (2 * i <= cerp_pkg::EASE_TABLE_ENTRIES) begin
               twice = one - cosine_q30(64'(i));
            end else begin
               twice = one + cosine_q30(64'(cerp_pkg::EASE_TABLE_ENTRIES - i));
            end
            ease_tab[i] = (twice + 64'd16384) >> 15;
         end
         ramp_low   = cerp_pkg::RAMP_LOW_RESET;
         ramp_high  = cerp_pkg::RAMP_HIGH_RESET;
         phase_step = cerp_pkg::PHASE_INC_RESET;
         phase      = '0;
         falling    = 1'b0;
      endfunction

      function void report(string msg);
         $display("MISMATCH @%0t: %s", $time, msg);
         failures++;
      endfunction

      function void set_reg(logic [cerp_pkg::CSR_INDEX_BITS-1:0] idx,
                            logic [cerp_pkg::CSR_DATA_BITS-1:0] data);
         reg_writes++;
         case (cerp_pkg::csr_index_type'(idx))
            cerp_pkg::CSR_RAMP_LOW:  ramp_low   = data[cerp_pkg::DUTY_BITS-1:0];
            cerp_pkg::CSR_RAMP_HIGH: ramp_high  = data[cerp_pkg::DUTY_BITS-1:0];
            cerp_pkg::CSR_PHASE_INC: phase_step = data[cerp_pkg::INC_BITS-1:0];
            default: ;
         endcase
      endfunction

      // linear interpolation between neighboring table entries, truncated
      function longint unsigned ease_at(logic [cerp_pkg::PHASE_BITS-1:0] ph);
         longint unsigned pos;
         longint unsigned idx;
         longint unsigned frac;
         longint unsigned lo_e;
         longint unsigned hi_e;
         pos  = longint'(ph) * cerp_pkg::EASE_TABLE_ENTRIES;
         idx  = pos >> cerp_pkg::PHASE_BITS;
         frac = pos & ((64'd1 << cerp_pkg::PHASE_BITS) - 1);
         if (idx >= cerp_pkg::EASE_TABLE_ENTRIES)
            return ease_tab[cerp_pkg::EASE_TABLE_ENTRIES];
         lo_e = ease_tab[idx];
         hi_e = ease_tab[idx+1];
         if (hi_e >= lo_e) return lo_e + (((hi_e - lo_e) * frac) >> cerp_pkg::PHASE_BITS);
         return lo_e - (((lo_e - hi_e) * frac) >> cerp_pkg::PHASE_BITS);
      endfunction

      function void note_tick(logic advance);
         duty_result_type res;
         longint unsigned from_d;
         longint unsigned to_d;
         longint unsigned e;
         longint unsigned d;
         longint unsigned sum;
         from_d = falling ? ramp_high : ramp_low;
         to_d   = falling ? ramp_low : ramp_high;
         e      = ease_at(phase);
         // a downward span rounds the step up so the duty stays a floor
         if (to_d >= from_d) d = from_d + ((e * (to_d - from_d)) >> 16);
         else                d = from_d - ((e * (from_d - to_d) + 64'd65535) >> 16);
         res.duty    = d[cerp_pkg::DUTY_BITS-1:0];
         res.falling = falling;
         res.wrapped = 1'b0;
         if (advance) begin
            sum = longint'(phase) + longint'(phase_step);
            if (sum >= (64'd1 << cerp_pkg::PHASE_BITS)) begin
               phase       = '0;
               falling     = ~falling;
               res.wrapped = 1'b1;
               wraps++;
            end else begin
               phase = sum[cerp_pkg::PHASE_BITS-1:0];
            end
         end
         if (res.falling) falling_ticks++;
         ticks++;
         pending_q.push_back(res);
      endfunction

      function void check_duty(logic [cerp_pkg::DUTY_BITS-1:0] duty, logic fall,
                               logic wrapped);
         duty_result_type want;
         if (pending_q.size() == 0) begin
            report($sformatf("rsp transfer with no tick outstanding: duty %0d", duty));
            return;
         end
         want = pending_q.pop_front();
         checked++;
         if (duty !== want.duty)
            report($sformatf("duty %0d, expected %0d", duty, want.duty));
         if (fall !== want.falling)
            report($sformatf("falling %b, expected %b", fall, want.falling));
         if (wrapped !== want.wrapped)
            report($sformatf("ramp_wrapped %b, expected %b", wrapped, want.wrapped));
      endfunction

   endclass

   logic                                clock;
   logic                                reset       = 1'b1;
   logic                                req_valid   = 1'b0;
   logic                                req_ready;
   logic                                req_advance = 1'b0;
   logic                                rsp_valid;
   logic                                rsp_ready   = 1'b0;
   logic [cerp_pkg::DUTY_BITS-1:0]      rsp_duty;
   logic                                rsp_falling;
   logic                                rsp_ramp_wrapped;
   logic                                csr_valid   = 1'b0;
   logic                                csr_ready;
   logic [cerp_pkg::CSR_INDEX_BITS-1:0] csr_index   = '0;
   logic [cerp_pkg::CSR_DATA_BITS-1:0]  csr_wdata   = '0;

   duty_scoreboard sb;
   bit             no_idle = 1'b0;
   int             quiet_cycles = 0;

   cosine_eased_pingpong_ramp_core i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_advance      (req_advance),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_duty         (rsp_duty),
      .rsp_falling      (rsp_falling),
      .rsp_ramp_wrapped (rsp_ramp_wrapped),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_ready <= no_idle || ($urandom_range(99) >= 6);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_duty(rsp_duty, rsp_falling, rsp_ramp_wrapped);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_valid && csr_ready)) begin
            quiet_cycles <= 0;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Watchdog: %0d cycles without a transfer", quiet_cycles);
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   // valid is left high after a transfer; it drops only when the sender idles
   task automatic send_tick(input logic advance);
      while (!no_idle && $urandom_range(99) < 6) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_advance <= advance;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_tick(advance);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending_q.size() != 0) @(posedge clock);
   endtask

   task automatic csr_put(input logic [cerp_pkg::CSR_INDEX_BITS-1:0] idx,
                          input logic [cerp_pkg::CSR_DATA_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.set_reg(idx, data);
   endtask

   task automatic write_regs(input logic [cerp_pkg::CSR_DATA_BITS-1:0] lo,
                             input logic [cerp_pkg::CSR_DATA_BITS-1:0] hi,
                             input logic [cerp_pkg::CSR_DATA_BITS-1:0] step,
                             input bit spare);
      csr_put(cerp_pkg::CSR_RAMP_LOW, lo);
      csr_put(cerp_pkg::CSR_RAMP_HIGH, hi);
      csr_put(cerp_pkg::CSR_PHASE_INC, step);
      if (spare) csr_put(CSR_SPARE, cerp_pkg::CSR_DATA_BITS'($urandom));
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic [cerp_pkg::CSR_DATA_BITS-1:0] lo;
      logic [cerp_pkg::CSR_DATA_BITS-1:0] hi;
      logic [cerp_pkg::CSR_DATA_BITS-1:0] step;
      int                                 pick;
      sb = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset values: report only, then a few steps
      send_tick(1'b0);
      send_tick(1'b1);
      send_tick(1'b1);
      send_tick(1'b0);
      wait_idle();

      // full span; half increment lands exactly on 1.0
      write_regs(16'd0, 16'hFFFF, 16'h8000, 1'b0);
      repeat (4) send_tick(1'b1);
      send_tick(1'b0);
      wait_idle();

      // endpoints swapped, max increment overshoots 1.0 and drops the excess
      write_regs(16'hFFFF, 16'd0, 16'hFFFF, 1'b0);
      repeat (3) send_tick(1'b1);
      send_tick(1'b0);
      wait_idle();

      // zero increment holds the phase; equal endpoints
      write_regs(16'd12345, 16'd12345, 16'd0, 1'b1);
      send_tick(1'b1);
      send_tick(1'b1);
      wait_idle();

      // phase runs up into the last table segment
      write_regs(16'd1, 16'hFFFE, 16'h3FFF, 1'b1);
      repeat (5) send_tick(1'b1);
      wait_idle();

      for (int seg = 0; seg < RAND_SEGMENTS; seg++) begin
         case ($urandom_range(4))
            0: begin lo = 16'd0;    hi = 16'hFFFF; end
            1: begin lo = 16'hFFFF; hi = 16'd0;    end
            2: begin
               lo = cerp_pkg::CSR_DATA_BITS'($urandom);
               hi = lo;
            end
            default: begin
               lo = cerp_pkg::CSR_DATA_BITS'($urandom);
               hi = cerp_pkg::CSR_DATA_BITS'($urandom);
            end
         endcase
         pick = $urandom_range(99);
         if (pick < 55)      step = cerp_pkg::CSR_DATA_BITS'($urandom_range(3000, 200));
         else if (pick < 75) step = cerp_pkg::CSR_DATA_BITS'($urandom_range(65535, 1));
         else if (pick < 90) step = cerp_pkg::CSR_DATA_BITS'($urandom_range(20000, 3000));
         else if (pick < 97) step = cerp_pkg::CSR_DATA_BITS'($urandom_range(40, 1));
         else                step = 16'd0;
         no_idle = (seg == STEADY_SEGMENT);
         write_regs(lo, hi, step, $urandom_range(3) == 0);
         for (int n = 0; n < SEGMENT_TICKS; n++) begin
            if ($urandom_range(99) < 2) wait_idle();
            send_tick($urandom_range(99) < 88);
         end
         wait_idle();
      end
      no_idle = 1'b0;

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.pending_q.size() != 0)
         sb.report($sformatf("%0d expected results never arrived", sb.pending_q.size()));

      $display("Covered %0d ticks (%0d on falling ramps), %0d ramp wraps, %0d register writes",
               sb.ticks, sb.falling_ticks, sb.wraps, sb.reg_writes);
      $display("Checked %0d results, %0d mismatches", sb.checked, sb.failures);
      if (sb.failures == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
design/cerp_pkg.sv
design/cerp_ease_lookup.sv
design/cerp_duty_blend.sv
design/cosine_eased_pingpong_ramp_core.sv
tb/tb_top.sv
